[design/dmtq_pkg.sv]
// Shared constants, codes and types of the delayed message timer queue.
`timescale 1ns / 1ps

package dmtq_pkg;

  // Number of entries held by the queue.
  localparam int QUEUE_DEPTH = 16;
  // Most entries that one tick may release.
  localparam int MAX_RESULTS = 16;

  localparam int DELTA_W = 16;
  localparam int ID_W    = 8;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int REL_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_RELEASED  = 2'd0,
    KIND_ACCEPTED  = 2'd1,
    KIND_ZERO_DELAY = 2'd2,
    KIND_FULL      = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    OP_TICK     = 1'b0,
    OP_SCHEDULE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_INSERT   = 2'd1,
    ST_POP      = 2'd2,
    ST_SET_HEAD = 2'd3
  } store_op_t;

  // Command from the sequencer to the entry store.
  typedef struct packed {
    store_op_t            op;
    logic [IDX_W-1:0]     pos;         // insert position
    logic [ID_W-1:0]      id;          // id of the new entry
    logic [DELTA_W-1:0]   delta;       // delta of the new entry, or new head delta
    logic [DELTA_W-1:0]   succ_delta;  // reduced delta of the entry after the new one
  } store_cmd_t;

endpackage

[design/dmtq_alu.sv]
// Shared 16-bit subtractor used for the delta walk, successor repair and tick decrement.
`timescale 1ns / 1ps

module dmtq_alu (
  input  logic [dmtq_pkg::DELTA_W-1:0] a,
  input  logic [dmtq_pkg::DELTA_W-1:0] b,
  output logic [dmtq_pkg::DELTA_W-1:0] diff,
  output logic                         borrow,
  output logic                         zero
);

  logic [dmtq_pkg::DELTA_W:0] full_diff;

  assign full_diff = {1'b0, a} - {1'b0, b};
  assign diff      = full_diff[dmtq_pkg::DELTA_W-1:0];
  assign borrow    = full_diff[dmtq_pkg::DELTA_W];
  assign zero      = (diff == '0);

endmodule

[design/dmtq_store.sv]
// Entry store of the delta list: ids and deltas with insert-shift and pop-shift.
`timescale 1ns / 1ps

module dmtq_store (
  input  logic                         clk,
  input  dmtq_pkg::store_cmd_t         cmd,
  input  logic [dmtq_pkg::IDX_W-1:0]   rd_pos,
  output logic [dmtq_pkg::DELTA_W-1:0] rd_delta,
  output logic [dmtq_pkg::ID_W-1:0]    head_id,
  output logic [dmtq_pkg::DELTA_W-1:0] head_delta,
  output logic [dmtq_pkg::DELTA_W-1:0] second_delta
);

  logic [dmtq_pkg::ID_W-1:0]    ids    [dmtq_pkg::QUEUE_DEPTH];
  logic [dmtq_pkg::DELTA_W-1:0] deltas [dmtq_pkg::QUEUE_DEPTH];

  assign rd_delta     = deltas[rd_pos];
  assign head_id      = ids[0];
  assign head_delta   = deltas[0];
  assign second_delta = deltas[1];

  always_ff @(posedge clk) begin
    for (int i = 0; i < dmtq_pkg::QUEUE_DEPTH; i++) begin
      unique case (cmd.op)
        dmtq_pkg::ST_INSERT: begin
          if (dmtq_pkg::IDX_W'(i) == cmd.pos) begin
            ids[i]    <= cmd.id;
            deltas[i] <= cmd.delta;
          end else if (dmtq_pkg::IDX_W'(i) > cmd.pos) begin
            if (i > 0) begin
              ids[i] <= ids[(i > 0) ? i - 1 : 0];
              if (dmtq_pkg::IDX_W'(i) == dmtq_pkg::IDX_W'(cmd.pos + 1'b1)) begin
                deltas[i] <= cmd.succ_delta;
              end else begin
                deltas[i] <= deltas[(i > 0) ? i - 1 : 0];
              end
            end
          end
        end
        dmtq_pkg::ST_POP: begin
          if (i < dmtq_pkg::QUEUE_DEPTH - 1) begin
            ids[i]    <= ids[(i < dmtq_pkg::QUEUE_DEPTH - 1) ? i + 1 : i];
            deltas[i] <= deltas[(i < dmtq_pkg::QUEUE_DEPTH - 1) ? i + 1 : i];
          end
        end
        dmtq_pkg::ST_SET_HEAD: begin
          if (i == 0) begin
            deltas[i] <= cmd.delta;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/delayed_message_timer_queue_core.sv]
// Top level of the delayed message timer queue: handshakes, sequencer and result register.
`timescale 1ns / 1ps

// Delta-list timer queue. Each input transaction is either a tick (tuser = 0) or a
// schedule request (tuser = 1) carrying a delay and a process id. Entries are kept in
// expiry order, each storing only its delay relative to the entry before it. A schedule
// request always produces exactly one result transaction with tlast set: accepted, zero
// delay rejected, or queue full, echoing the process id. A tick decrements the head
// delta; when it reaches zero, the head and all following zero-delta entries (at most
// sixteen) are released in order, one result each, with tlast on the final one. A tick
// on an empty queue, or one that only decrements, produces nothing. The block handles
// one transaction at a time and all arithmetic runs through a single 16-bit subtractor
// under a small sequencer. A rejected schedule is answered straight from idle. An
// accepted schedule walks past P entries (at most QUEUE_DEPTH - 1), one
// compare-and-subtract per cycle, and then inserts. A tick on an empty queue is dropped
// in idle; any other tick decrements the head, then releases expired entries one per
// cycle while the result register is free. A full result register stalls the
// sequencer until the downstream side takes the pending transaction. There is no
// clearing pass after reset; stale slots past the fill count never affect a result.
module delayed_message_timer_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] delay_ticks, [23:16] process_id
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] released_id
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_WALK    = 5'b00010,
    S_INSERT  = 5'b00100,
    S_DEC     = 5'b01000,
    S_RELEASE = 5'b10000
  } state_t;

  state_t state;

  logic [dmtq_pkg::CNT_W-1:0]   count;
  logic [dmtq_pkg::CNT_W-1:0]   pos;
  logic [dmtq_pkg::REL_W-1:0]   n_rel;
  logic [dmtq_pkg::DELTA_W-1:0] rem;
  logic [dmtq_pkg::ID_W-1:0]    sched_id;

  logic [dmtq_pkg::DELTA_W-1:0] in_delay;
  logic [dmtq_pkg::ID_W-1:0]    in_id;
  logic                         in_accept;
  logic                         out_free;
  logic                         out_load;

  dmtq_pkg::store_cmd_t         cmd;
  logic [dmtq_pkg::DELTA_W-1:0] rd_delta;
  logic [dmtq_pkg::ID_W-1:0]    head_id;
  logic [dmtq_pkg::DELTA_W-1:0] head_delta;
  logic [dmtq_pkg::DELTA_W-1:0] second_delta;

  logic [dmtq_pkg::DELTA_W-1:0] alu_a;
  logic [dmtq_pkg::DELTA_W-1:0] alu_b;
  logic [dmtq_pkg::DELTA_W-1:0] alu_diff;
  logic                         alu_borrow;
  logic                         alu_zero;

  logic                         walk_on;
  logic                         more_rel;

  assign in_delay  = s_axis_tdata[15:0];
  assign in_id     = s_axis_tdata[23:16];
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && out_free;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // A new result enters the output register this cycle; it replaces any result leaving it.
  assign out_load = ((state == S_IDLE) && in_accept
                     && (s_axis_tuser[0] == dmtq_pkg::OP_SCHEDULE)
                     && ((in_delay == '0)
                         || (count >= dmtq_pkg::CNT_W'(dmtq_pkg::QUEUE_DEPTH))))
                 || ((state == S_INSERT) && out_free)
                 || ((state == S_RELEASE) && (head_delta == '0) && out_free);

  // The walk continues while the remaining delay is strictly greater than the entry's delta.
  assign walk_on = (pos < count) && !alu_borrow && !alu_zero;

  // Another release follows if the next entry exists, has delta zero and the limit allows it.
  assign more_rel = (count > dmtq_pkg::CNT_W'(1))
                 && (n_rel + 1'b1 < dmtq_pkg::REL_W'(dmtq_pkg::MAX_RESULTS))
                 && (second_delta == '0);

  // Operand selection for the shared subtractor.
  always_comb begin
    unique case (state)
      S_INSERT: begin
        alu_a = rd_delta;
        alu_b = rem;
      end
      S_DEC: begin
        alu_a = head_delta;
        alu_b = dmtq_pkg::DELTA_W'(1);
      end
      default: begin
        alu_a = rem;
        alu_b = rd_delta;
      end
    endcase
  end

  dmtq_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow),
    .zero   (alu_zero)
  );

  // Store command for this cycle.
  always_comb begin
    cmd            = '0;
    cmd.op         = dmtq_pkg::ST_NONE;
    cmd.pos        = pos[dmtq_pkg::IDX_W-1:0];
    cmd.id         = sched_id;
    cmd.delta      = rem;
    cmd.succ_delta = alu_diff;
    unique case (state)
      S_INSERT: begin
        if (out_free) begin
          cmd.op = dmtq_pkg::ST_INSERT;
        end
      end
      S_DEC: begin
        if (head_delta != '0) begin
          cmd.op    = dmtq_pkg::ST_SET_HEAD;
          cmd.delta = alu_diff;
        end
      end
      S_RELEASE: begin
        if (head_delta == '0 && out_free) begin
          cmd.op = dmtq_pkg::ST_POP;
        end
      end
      default: begin
      end
    endcase
  end

  dmtq_store u_store (
    .clk          (clk),
    .cmd          (cmd),
    .rd_pos       (pos[dmtq_pkg::IDX_W-1:0]),
    .rd_delta     (rd_delta),
    .head_id      (head_id),
    .head_delta   (head_delta),
    .second_delta (second_delta)
  );

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (s_axis_tuser[0] == dmtq_pkg::OP_SCHEDULE) begin
              if (in_delay == '0) begin
                m_axis_tvalid <= 1'b1;
                m_axis_tuser  <= dmtq_pkg::KIND_ZERO_DELAY;
                m_axis_tdata  <= in_id;
                m_axis_tlast  <= 1'b1;
              end else if (count >= dmtq_pkg::CNT_W'(dmtq_pkg::QUEUE_DEPTH)) begin
                m_axis_tvalid <= 1'b1;
                m_axis_tuser  <= dmtq_pkg::KIND_FULL;
                m_axis_tdata  <= in_id;
                m_axis_tlast  <= 1'b1;
              end else begin
                rem      <= in_delay;
                sched_id <= in_id;
                pos      <= '0;
                state    <= S_WALK;
              end
            end else if (count != '0) begin
              n_rel <= '0;
              state <= S_DEC;
            end
          end
        end
        S_WALK: begin
          if (walk_on) begin
            rem <= alu_diff;
            pos <= pos + 1'b1;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (out_free) begin
            count         <= count + 1'b1;
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= dmtq_pkg::KIND_ACCEPTED;
            m_axis_tdata  <= sched_id;
            m_axis_tlast  <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_DEC: begin
          state <= S_RELEASE;
        end
        S_RELEASE: begin
          if (head_delta != '0) begin
            state <= S_IDLE;
          end else if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= dmtq_pkg::KIND_RELEASED;
            m_axis_tdata  <= head_id;
            m_axis_tlast  <= !more_rel;
            count         <= count - 1'b1;
            n_rel         <= n_rel + 1'b1;
            if (!more_rel) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dmtq_pkg::CNT_W'(dmtq_pkg::QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (pos <= count))
    else $error("insert walk passed the fill count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT && out_free) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the queue by one");

  a_release_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_RELEASE && out_free && head_delta == '0) |=>
      (m_axis_tvalid && m_axis_tuser == dmtq_pkg::KIND_RELEASED))
    else $error("expired head was not presented as a release");

endmodule

[sim/delayed_message_timer_queue_core_tb.sv]
// Self-checking testbench for the delayed message timer queue core.
`timescale 1ns / 1ps

module delayed_message_timer_queue_core_tb;

  // One result transaction as the core should present it.
  typedef struct packed {
    dmtq_pkg::kind_t kind;
    logic [7:0]      id;
    logic            last;
  } timer_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [15:0] delay_ticks, [23:16] process_id
  logic [0:0]  s_axis_tuser = '0;   // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] released_id
  logic [1:0]  m_axis_tuser;        // [1:0] kind
  logic        m_axis_tlast;

  delayed_message_timer_queue_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Shadow copy of the delta list, updated as each input transaction is accepted.
  logic [7:0]    timer_ids [dmtq_pkg::QUEUE_DEPTH];
  logic [15:0]   timer_deltas [dmtq_pkg::QUEUE_DEPTH];
  int            shadow_fill = 0;

  // Results the core still owes us, oldest first.
  timer_result_t pending_results [$];

  int fail_count     = 0;
  int send_idle_pct  = 0;   // chance per cycle that the sender leaves tvalid low
  int recv_stall_pct = 0;   // chance per cycle that the receiver drops tready
  int hold_req       = 0;   // request for a long receiver hold-off, in cycles
  int hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Schedule request: refuse a zero delay or a full queue; else find the insertion point
  // by walking the deltas, cut the successor's delta down by what is left, and shift the tail up one slot.
  function automatic void predict_schedule(input logic [15:0] dly, input logic [7:0] pid);
    int            pos;
    int            i;
    logic [15:0]   remaining;
    timer_result_t r;
    r.id   = pid;
    r.last = 1'b1;
    if (dly == 16'd0) begin
      r.kind = dmtq_pkg::KIND_ZERO_DELAY;
    end else if (shadow_fill >= dmtq_pkg::QUEUE_DEPTH) begin
      r.kind = dmtq_pkg::KIND_FULL;
    end else begin
      pos       = 0;
      remaining = dly;
      while (pos < shadow_fill && remaining > timer_deltas[pos]) begin
        remaining = remaining - timer_deltas[pos];
        pos++;
      end
      if (pos < shadow_fill) begin
        timer_deltas[pos] = timer_deltas[pos] - remaining;
        for (i = shadow_fill; i > pos; i--) begin
          timer_ids[i]    = timer_ids[i-1];
          timer_deltas[i] = timer_deltas[i-1];
        end
      end
      timer_ids[pos]    = pid;
      timer_deltas[pos] = remaining;
      shadow_fill++;
      r.kind = dmtq_pkg::KIND_ACCEPTED;
    end
    pending_results.push_back(r);
  endfunction

  // Tick: decrement a nonzero head, then release the run of zero deltas at the head.
  function automatic void predict_tick();
    int            n;
    int            i;
    timer_result_t r;
    if (shadow_fill == 0) return;
    if (timer_deltas[0] != 16'd0) timer_deltas[0] = timer_deltas[0] - 16'd1;
    n = 0;
    while (n < shadow_fill && n < dmtq_pkg::MAX_RESULTS && timer_deltas[n] == 16'd0) n++;
    for (i = 0; i < n; i++) begin
      r.kind = dmtq_pkg::KIND_RELEASED;
      r.id   = timer_ids[i];
      r.last = (i == n - 1);
      pending_results.push_back(r);
    end
    for (i = 0; i < shadow_fill - n; i++) begin
      timer_ids[i]    = timer_ids[i+n];
      timer_deltas[i] = timer_deltas[i+n];
    end
    shadow_fill = shadow_fill - n;
  endfunction

  // Offers one transaction, with random gaps before it, and waits until the core takes
  // it. tvalid stays high afterwards so that back-to-back transactions need no gap.
  task automatic send_item(input dmtq_pkg::opcode_t op, input logic [15:0] dly,
                           input logic [7:0] pid);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pid, dly};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    if (op == dmtq_pkg::OP_SCHEDULE) predict_schedule(dly, pid);
    else predict_tick();
  endtask

  task automatic send_tick();
    send_item(dmtq_pkg::OP_TICK, 16'($urandom), 8'($urandom));
  endtask

  // Mostly short delays so that entries expire within the run; a few longer ones.
  function automatic logic [15:0] random_delay();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) return 16'd0;
    if (pick < 70) return 16'($urandom_range(1, 8));
    if (pick < 92) return 16'($urandom_range(9, 64));
    return 16'($urandom_range(65, 400));
  endfunction

  // Receiver side: random stalls, plus a long hold-off when the test asks for one.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every result transaction is checked against the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    timer_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d id %0d last %0d",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata !== want.id) begin
          $error("released_id: expected %0d, actual %0d", want.id, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // A tick with nothing queued stays silent; a zero delay is refused.
  task automatic test_empty_tick_and_zero_delay();
    send_tick();
    send_item(dmtq_pkg::OP_SCHEDULE, 16'd0, 8'h5A);
  endtask

  // Sixteen entries with equal delay fill the queue, the next request is refused as
  // full, and the third tick releases all sixteen in one burst.
  task automatic test_fill_and_mass_release();
    int i;
    for (i = 0; i < dmtq_pkg::QUEUE_DEPTH; i++) begin
      send_item(dmtq_pkg::OP_SCHEDULE, 16'd3, 8'(i * 17));
    end
    send_item(dmtq_pkg::OP_SCHEDULE, 16'd3, 8'hC3);
    repeat (3) send_tick();
  endtask

  // Ordering corners: extreme ids and delays, an equal delay that must land in front
  // of the existing entry, and a new head.
  task automatic test_insert_order();
    send_item(dmtq_pkg::OP_SCHEDULE, 16'd5, 8'h00);
    send_item(dmtq_pkg::OP_SCHEDULE, 16'hFFFF, 8'hFF);
    send_item(dmtq_pkg::OP_SCHEDULE, 16'd5, 8'hAA);
    send_item(dmtq_pkg::OP_SCHEDULE, 16'd1, 8'h3C);
  endtask

  task automatic test_random_traffic(input int n_items);
    int          sent;
    int          pick;
    int          burst_len;
    logic [15:0] burst_delay;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // A burst of equal delays, then enough ticks to bring them due together.
        burst_len   = $urandom_range(2, 6);
        burst_delay = 16'($urandom_range(1, 4));
        repeat (burst_len) send_item(dmtq_pkg::OP_SCHEDULE, burst_delay, 8'($urandom));
        repeat (burst_delay) send_tick();
        sent += burst_len + burst_delay;
      end else if (pick < 57) begin
        send_item(dmtq_pkg::OP_SCHEDULE, random_delay(), 8'($urandom));
        sent++;
      end else begin
        send_tick();
        sent++;
      end
    end
  endtask

  // The receiver goes quiet for a long time while requests keep coming, so the result
  // register fills and the core has to hold off its input.
  task automatic test_backpressure_fill();
    hold_req = 300;
    repeat (24) begin
      if ($urandom_range(99) < 70) begin
        send_item(dmtq_pkg::OP_SCHEDULE, random_delay(), 8'($urandom));
      end else begin
        send_tick();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct  = 25;
    recv_stall_pct = 56;
    test_empty_tick_and_zero_delay();
    test_fill_and_mass_release();
    test_insert_order();
    test_random_traffic(130);
    test_backpressure_fill();

    send_idle_pct  = 56;
    recv_stall_pct = 25;
    test_random_traffic(120);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(110);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Give a late or duplicated result time to show up.
    repeat (60) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS delayed_message_timer_queue_core");
    end else begin
      $display("FAIL delayed_message_timer_queue_core");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL delayed_message_timer_queue_core");
    $finish;
  end

endmodule

[sim.f]
design/dmtq_pkg.sv
design/dmtq_alu.sv
design/dmtq_store.sv
design/delayed_message_timer_queue_core.sv
sim/delayed_message_timer_queue_core_tb.sv
